// File: src/aatl_pkg.sv
// Shared types and constants for the antialiased thick line pixel shader.
`timescale 1ns / 1ps
package aatl_pkg;

	localparam int CANVAS_WIDTH_DEF  = 1024;
	localparam int CANVAS_HEIGHT_DEF = 1024;

	// 0.01 pixel in Q.8
	localparam logic [16:0] EPS_Q8 = 17'd3;

	localparam int H_BITS = 17;   // distance quotient bits, Q.8, saturated
	localparam int F_BITS = 8;    // fade quotient bits, Q0.8
	localparam int L_BITS = 22;   // root of a 44-bit value

	// register indexes
	localparam logic [2:0] REG_LINE_START  = 3'd0;
	localparam logic [2:0] REG_LINE_END    = 3'd1;
	localparam logic [2:0] REG_LINE_COLOR  = 3'd2;
	localparam logic [2:0] REG_INNER_DIST  = 3'd3;
	localparam logic [2:0] REG_OUTER_DIST  = 3'd4;
	localparam logic [2:0] REG_CLIP_ENABLE = 3'd5;
	localparam logic [2:0] REG_CLIP_LOW    = 3'd6;
	localparam logic [2:0] REG_CLIP_HIGH   = 3'd7;

	typedef enum logic [3:0] {
		LS_IDLE = 4'b0001,
		LS_SQR  = 4'b0010,
		LS_SUM  = 4'b0100,
		LS_ROOT = 4'b1000
	} len_state_t;

	typedef struct packed {
		logic [7:0] old_b;
		logic [7:0] old_g;
		logic [7:0] old_r;
		logic       draw;
	} side_t;

endpackage

// File: src/aa_thick_line_pixel_shader_top.sv
// Top level: pipelined antialiased thick line pixel shader with APB registers.
`timescale 1ns / 1ps
// One pixel transfer enters per clock while s_tready is high; with m_tready
// held high and the root unit idle the block sustains one pixel per cycle.
// Most of the pipeline is taken by the two long divisions, distance =
// |cross| / length (17 stages, one quotient bit each) and fade =
// (outer - h) / (outer - inner) (8 stages). The segment length is a square
// root of the configured endpoints, worked out by a serial root unit that
// restarts on every write to line_start or line_end; s_tready is low until
// it finishes after the last such write. Configure only while no
// pixel is in flight. Pixels off the canvas, outside the clip window (when
// enabled) or outside the segment box grown by inner_dist pass through with
// touched = 0; a zero-length segment draws nothing.
module aa_thick_line_pixel_shader_top #(
	parameter int CANVAS_WIDTH  = aatl_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = aatl_pkg::CANVAS_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// pixel in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12], old_blue[31:24],
	                               // old_green[39:32], old_red[47:40]
	// pixel out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // new_blue[7:0], new_green[15:8], new_red[23:16]
	output logic [0:0]  m_tuser,   // touched[0]
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import aatl_pkg::*;

	localparam int HN = H_BITS;
	localparam int FN = F_BITS;

	// subtractive mix, saturating at black
	function automatic logic [7:0] mix_byte(input logic [7:0] old, input logic [7:0] c);
		logic [8:0] fin;
		fin = {1'b0, ~old} + {1'b0, ~c};
		return fin[8] ? 8'd0 : ~fin[7:0];
	endfunction

	// ---------------- registers ----------------
	logic [31:0] line_start_q, line_end_q;
	logic [23:0] line_color_q;
	logic [11:0] inner_q, outer_q;
	logic        clip_en_q;
	logic [23:0] clip_low_q, clip_high_q;

	logic       wr_en;
	logic [2:0] wr_idx;
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= '0;
			line_end_q   <= '0;
			line_color_q <= '0;
			inner_q      <= 12'd32;
			outer_q      <= 12'd32;
			clip_en_q    <= 1'b0;
			clip_low_q   <= '0;
			clip_high_q  <= 24'hFFFFFF;
		end else if (wr_en) begin
			case (wr_idx)
				REG_LINE_START:  line_start_q <= pwdata;
				REG_LINE_END:    line_end_q   <= pwdata;
				REG_LINE_COLOR:  line_color_q <= pwdata[23:0];
				REG_INNER_DIST:  inner_q      <= pwdata[11:0];
				REG_OUTER_DIST:  outer_q      <= pwdata[11:0];
				REG_CLIP_ENABLE: clip_en_q    <= pwdata[0];
				REG_CLIP_LOW:    clip_low_q   <= pwdata[23:0];
				REG_CLIP_HIGH:   clip_high_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_LINE_START:  prdata = line_start_q;
			REG_LINE_END:    prdata = line_end_q;
			REG_LINE_COLOR:  prdata = {8'd0, line_color_q};
			REG_INNER_DIST:  prdata = {20'd0, inner_q};
			REG_OUTER_DIST:  prdata = {20'd0, outer_q};
			REG_CLIP_ENABLE: prdata = {31'd0, clip_en_q};
			REG_CLIP_LOW:    prdata = {8'd0, clip_low_q};
			REG_CLIP_HIGH:   prdata = {8'd0, clip_high_q};
			default:         prdata = '0;
		endcase
	end

	// segment geometry from the registers
	logic signed [15:0] sx, sy, tx, ty;
	logic signed [16:0] dx, dy;
	assign sx = line_start_q[31:16];
	assign sy = line_start_q[15:0];
	assign tx = line_end_q[31:16];
	assign ty = line_end_q[15:0];
	assign dx = 17'(tx) - 17'(sx);
	assign dy = 17'(ty) - 17'(sy);

	logic [15:0] in16, out16, den16;
	assign in16  = {inner_q, 4'd0};
	assign out16 = {outer_q, 4'd0};
	assign den16 = out16 - in16;

	// ---------------- length unit: L = isqrt(len2 << 8) ----------------
	len_state_t         ls_q;
	logic [33:0]        sqx_q, sqy_q;
	logic [43:0]        rad_q;
	logic [24:0]        rrem_q;
	logic [L_BITS-1:0]  root_q, len_q;
	logic [4:0]         rcnt_q;
	logic               lz_q;
	logic signed [33:0] sqx_w, sqy_w;
	logic [34:0]        len2_w;
	logic [24:0]        rrem_t, rtrial;

	assign sqx_w  = dx * dx;
	assign sqy_w  = dy * dy;
	assign len2_w = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign rrem_t = {rrem_q[22:0], rad_q[43:42]};
	assign rtrial = {1'b0, root_q, 2'b01};

	// any endpoint write restarts the root, so back-to-back writes are safe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q   <= LS_IDLE;
			rcnt_q <= '0;
			lz_q   <= 1'b1;
		end else if (wr_en && (wr_idx == REG_LINE_START || wr_idx == REG_LINE_END)) begin
			ls_q <= LS_SQR;
		end else begin
			case (ls_q)
				LS_IDLE: ;
				LS_SQR:  ls_q <= LS_SUM;
				LS_SUM: begin
					lz_q   <= (len2_w == '0);
					rcnt_q <= 5'(L_BITS - 1);
					ls_q   <= LS_ROOT;
				end
				LS_ROOT: begin
					if (rcnt_q == '0)
						ls_q <= LS_IDLE;
					else
						rcnt_q <= rcnt_q - 5'd1;
				end
				default: ls_q <= LS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ls_q)
			LS_SQR: begin
				sqx_q <= 34'(sqx_w);
				sqy_q <= 34'(sqy_w);
			end
			LS_SUM: begin
				rad_q  <= {1'b0, len2_w, 8'd0};
				rrem_q <= '0;
				root_q <= '0;
			end
			LS_ROOT: begin
				rad_q <= {rad_q[41:0], 2'b00};
				if (rrem_t >= rtrial) begin
					rrem_q <= rrem_t - rtrial;
					root_q <= {root_q[L_BITS-2:0], 1'b1};
				end else begin
					rrem_q <= rrem_t;
					root_q <= {root_q[L_BITS-2:0], 1'b0};
				end
				if (rcnt_q == '0)
					len_q <= (rrem_t >= rtrial) ? {root_q[L_BITS-2:0], 1'b1}
					                            : {root_q[L_BITS-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	// ---------------- pipeline ----------------
	logic adv;
	logic valid_out_s;
	assign adv      = !valid_out_s || m_tready;
	assign s_tready = adv && (ls_q == LS_IDLE);

	// s1: input capture
	logic        v_s1;
	logic [11:0] px_s1, py_s1;
	side_t       side_s1;

	// s2: window tests, offsets from start point
	logic               v_s2;
	side_t              side_s2;
	logic signed [17:0] relx_s2, rely_s2;
	logic               in_canvas, in_clip, in_box;
	logic signed [17:0] qx, qy, di, bx_lo, bx_hi, by_lo, by_hi;
	assign qx = {2'b00, px_s1, 4'd0};
	assign qy = {2'b00, py_s1, 4'd0};
	assign di = {6'd0, inner_q};
	assign bx_lo = ((sx < tx) ? 18'(sx) : 18'(tx)) - di;
	assign bx_hi = ((sx < tx) ? 18'(tx) : 18'(sx)) + di;
	assign by_lo = ((sy < ty) ? 18'(sy) : 18'(ty)) - di;
	assign by_hi = ((sy < ty) ? 18'(ty) : 18'(sy)) + di;
	assign in_canvas = ({1'b0, px_s1} < 13'(CANVAS_WIDTH)) &&
	                   ({1'b0, py_s1} < 13'(CANVAS_HEIGHT));
	assign in_clip = !clip_en_q ||
		(clip_low_q[23:12] <= px_s1 && px_s1 < clip_high_q[23:12] &&
		 clip_low_q[11:0]  <= py_s1 && py_s1 < clip_high_q[11:0]);
	assign in_box = bx_lo <= qx && qx <= bx_hi && by_lo <= qy && qy <= by_hi;

	// s3: cross product terms
	logic               v_s3;
	side_t              side_s3;
	logic signed [34:0] p1_s3, p2_s3;

	// s4: |cross|
	logic               v_s4;
	side_t              side_s4;
	logic [35:0]        ac_s4;
	logic signed [35:0] cr;
	assign cr = 36'(p1_s3) - 36'(p2_s3);

	// distance divider: index 0 is the setup stage, k+1 after quotient bit 16-k
	logic          hv_s   [0:HN];
	side_t         hside_s[0:HN];
	logic          hsat_s [0:HN];
	logic [43:0]   hrem_s [0:HN];
	logic [HN-1:0] hq_s   [0:HN];

	// fade divider: index 0 is the classify stage
	logic          fv_s   [0:FN];
	side_t         fside_s[0:FN];   // draw now means touched
	logic          ffull_s[0:FN];
	logic [23:0]   frem_s [0:FN];
	logic [FN-1:0] fq_s   [0:FN];

	// fade products
	logic        v_s6;
	side_t       side_s6;
	logic        full_s6;
	logic [15:0] mb_s6, mg_s6, mr_s6;

	// output
	logic [7:0] nb_out_s, ng_out_s, nr_out_s;
	logic       hit_out_s;

	// classify signals
	logic [HN-1:0] h_w;
	logic          full_w, fade_w;
	assign h_w    = hsat_s[HN] ? '1 : hq_s[HN];
	assign full_w = h_w < (17'(in16) + EPS_Q8);
	assign fade_w = h_w < 17'(out16);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			hv_s[0] <= 1'b0;
			fv_s[0] <= 1'b0;
			v_s6 <= 1'b0;
			valid_out_s <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid && s_tready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			hv_s[0] <= v_s4;
			fv_s[0] <= hv_s[HN];
			v_s6 <= fv_s[FN];
			valid_out_s <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1   <= s_tdata[11:0];
			py_s1   <= s_tdata[23:12];
			side_s1 <= {s_tdata[31:24], s_tdata[39:32], s_tdata[47:40], 1'b0};

			side_s2 <= {side_s1.old_b, side_s1.old_g, side_s1.old_r,
				in_canvas && in_clip && in_box};
			relx_s2 <= qx - 18'(sx);
			rely_s2 <= qy - 18'(sy);

			side_s3 <= side_s2;
			p1_s3   <= 35'(dx * rely_s2);
			p2_s3   <= 35'(dy * relx_s2);

			side_s4 <= side_s3;
			ac_s4   <= cr[35] ? 36'(-cr) : 36'(cr);

			hside_s[0] <= side_s4;
			hsat_s[0]  <= ac_s4 >= {5'd0, len_q, 9'd0};
			hrem_s[0]  <= {ac_s4, 8'd0};
			hq_s[0]    <= '0;

			fside_s[0] <= {hside_s[HN].old_b, hside_s[HN].old_g, hside_s[HN].old_r,
				hside_s[HN].draw && !lz_q && (full_w || fade_w)};
			ffull_s[0] <= full_w;
			frem_s[0]  <= {out16 - h_w[15:0], 8'd0};
			fq_s[0]    <= '0;

			side_s6 <= fside_s[FN];
			full_s6 <= ffull_s[FN];
			mb_s6   <= {8'd0, ~line_color_q[7:0]}   * {8'd0, fq_s[FN]};
			mg_s6   <= {8'd0, ~line_color_q[15:8]}  * {8'd0, fq_s[FN]};
			mr_s6   <= {8'd0, ~line_color_q[23:16]} * {8'd0, fq_s[FN]};

			hit_out_s <= side_s6.draw;
			nb_out_s  <= side_s6.draw ? mix_byte(side_s6.old_b,
				full_s6 ? line_color_q[7:0] : ~mb_s6[15:8]) : side_s6.old_b;
			ng_out_s  <= side_s6.draw ? mix_byte(side_s6.old_g,
				full_s6 ? line_color_q[15:8] : ~mg_s6[15:8]) : side_s6.old_g;
			nr_out_s  <= side_s6.draw ? mix_byte(side_s6.old_r,
				full_s6 ? line_color_q[23:16] : ~mr_s6[15:8]) : side_s6.old_r;
		end
	end

	// h = (|cross| << 8) / L, one quotient bit per stage
	for (genvar k = 0; k < HN; k++) begin : g_hdiv
		localparam int B = HN - 1 - k;
		logic [43:0] trial;
		assign trial = 44'(len_q) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				hv_s[k+1] <= 1'b0;
			else if (adv)
				hv_s[k+1] <= hv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hside_s[k+1] <= hside_s[k];
				hsat_s[k+1]  <= hsat_s[k];
				if (hrem_s[k] >= trial) begin
					hrem_s[k+1] <= hrem_s[k] - trial;
					hq_s[k+1]   <= hq_s[k] | (HN'(1) << B);
				end else begin
					hrem_s[k+1] <= hrem_s[k];
					hq_s[k+1]   <= hq_s[k];
				end
			end
		end
	end

	// f = ((outer - h) << 8) / (outer - inner), below 256 in the fade band
	for (genvar k = 0; k < FN; k++) begin : g_fdiv
		localparam int B = FN - 1 - k;
		logic [23:0] trial;
		assign trial = 24'(den16) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				fv_s[k+1] <= 1'b0;
			else if (adv)
				fv_s[k+1] <= fv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fside_s[k+1] <= fside_s[k];
				ffull_s[k+1] <= ffull_s[k];
				if (frem_s[k] >= trial) begin
					frem_s[k+1] <= frem_s[k] - trial;
					fq_s[k+1]   <= fq_s[k] | (FN'(1) << B);
				end else begin
					frem_s[k+1] <= frem_s[k];
					fq_s[k+1]   <= fq_s[k];
				end
			end
		end
	end

	assign m_tvalid   = valid_out_s;
	assign m_tdata    = {nr_out_s, ng_out_s, nb_out_s};
	assign m_tuser[0] = hit_out_s;

endmodule
